[rtl/ilffa_pkg.sv]
// Package for the implicit-list first-fit allocator.
// Holds item types, register and opcode codes, controller types and sizing constants.
// Used by every module in rtl/ except ilffa_ram; depends on nothing.
package ilffa_pkg;

  localparam int unsigned HEAP_BYTES_DEF = 65536;
  localparam int unsigned BLK_BYTES      = 16;
  localparam int unsigned HDR_BYTES      = 8;
  localparam int unsigned MIN_HEAP_BYTES = 64;
  localparam int unsigned REQ_W          = 17;
  localparam int unsigned ADDR_W         = 32;
  localparam int unsigned HB_W           = 17;
  localparam logic [HB_W-1:0] HEAP_BYTES_RST = 17'h10000;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_BYTES = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] release_address;
  } in_item_t;

  typedef struct packed {
    logic              failed;
    logic [ADDR_W-1:0] payload_address;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_SPLIT,
    ST_RDNXT,
    ST_EVNXT,
    ST_MERGE,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic load_req;
    logic init_wr;
    logic rd_next;
    logic step;
    logic wr_alloc;
    logic wr_split;
    logic hold_match;
    logic latch_next;
    logic wr_merge;
    logic set_fail;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_free;
    logic at_end;
    logic fit;
    logic split;
    logic hit;
    logic next_in;
    logic out_free;
  } ctrl_sts_t;

endpackage

[rtl/ilffa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ilffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/ilffa_ctrl.sv]
// Controller of the allocator: walks the block list one header at a time.
// Depends on ilffa_pkg.
module ilffa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  relayout_i,
  input  ilffa_pkg::ctrl_sts_t  sts_i,
  output ilffa_pkg::ctrl_cmd_t  cmd_o
);

  ilffa_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ilffa_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign cfg_ready_o = (state_q == ilffa_pkg::ST_IDLE);
  assign in_stall_o  = !((state_q == ilffa_pkg::ST_IDLE) && !cfg_valid_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ilffa_pkg::ST_INIT: state_d = ilffa_pkg::ST_IDLE;
      ilffa_pkg::ST_IDLE: begin
        if (relayout_i) begin
          state_d = ilffa_pkg::ST_INIT;
        end else if (in_valid_i && !cfg_valid_i) begin
          state_d = ilffa_pkg::ST_READ;
        end
      end
      ilffa_pkg::ST_READ: begin
        state_d = sts_i.at_end ? ilffa_pkg::ST_DONE : ilffa_pkg::ST_EVAL;
      end
      ilffa_pkg::ST_EVAL: begin
        if (!sts_i.op_free) begin
          if (sts_i.fit) begin
            state_d = sts_i.split ? ilffa_pkg::ST_SPLIT : ilffa_pkg::ST_DONE;
          end else begin
            state_d = ilffa_pkg::ST_READ;
          end
        end else if (sts_i.hit) begin
          state_d = sts_i.next_in ? ilffa_pkg::ST_RDNXT : ilffa_pkg::ST_MERGE;
        end else begin
          state_d = ilffa_pkg::ST_READ;
        end
      end
      ilffa_pkg::ST_SPLIT: state_d = ilffa_pkg::ST_DONE;
      ilffa_pkg::ST_RDNXT: state_d = ilffa_pkg::ST_EVNXT;
      ilffa_pkg::ST_EVNXT: state_d = ilffa_pkg::ST_MERGE;
      ilffa_pkg::ST_MERGE: state_d = ilffa_pkg::ST_DONE;
      ilffa_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = ilffa_pkg::ST_IDLE;
        end
      end
      default: state_d = ilffa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ilffa_pkg::ST_INIT: cmd_o.init_wr = 1'b1;
      ilffa_pkg::ST_IDLE: cmd_o.load_req = in_valid_i && !cfg_valid_i;
      ilffa_pkg::ST_READ: cmd_o.set_fail = sts_i.at_end;
      ilffa_pkg::ST_EVAL: begin
        if (!sts_i.op_free) begin
          cmd_o.wr_alloc = sts_i.fit;
          cmd_o.step     = !sts_i.fit;
        end else begin
          cmd_o.hold_match = sts_i.hit;
          cmd_o.step       = !sts_i.hit;
        end
      end
      ilffa_pkg::ST_SPLIT: cmd_o.wr_split = 1'b1;
      ilffa_pkg::ST_RDNXT: cmd_o.rd_next = 1'b1;
      ilffa_pkg::ST_EVNXT: cmd_o.latch_next = 1'b1;
      ilffa_pkg::ST_MERGE: cmd_o.wr_merge = 1'b1;
      ilffa_pkg::ST_DONE:  cmd_o.out_load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

[rtl/ilffa_dp.sv]
// Datapath of the allocator: header store, walk registers and result register.
// Depends on ilffa_pkg and ilffa_ram.
module ilffa_dp #(
  parameter int unsigned HEAP_BYTES = ilffa_pkg::HEAP_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ilffa_pkg::ctrl_cmd_t         cmd_i,
  output ilffa_pkg::ctrl_sts_t         sts_o,
  input  ilffa_pkg::in_item_t          in_data_i,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [ilffa_pkg::ADDR_W-1:0] cfg_wdata_i,
  output logic                         out_valid_o,
  output ilffa_pkg::out_item_t         out_data_o,
  input  logic                         out_stall_i
);

  localparam int unsigned DEPTH = HEAP_BYTES / ilffa_pkg::BLK_BYTES;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned SZ_W  = $clog2(HEAP_BYTES + 1);
  localparam int unsigned CW    = ((SZ_W > 18) ? SZ_W : 18) + 1;
  localparam int unsigned ENT_W = SZ_W + 1;

  function automatic logic [SZ_W-1:0] end_of(input logic [ilffa_pkg::HB_W-1:0] hb);
    logic [CW-1:0] len;
    len = CW'(hb);
    if (len > CW'(HEAP_BYTES)) len = CW'(HEAP_BYTES);
    if (len < CW'(ilffa_pkg::MIN_HEAP_BYTES)) len = CW'(ilffa_pkg::MIN_HEAP_BYTES);
    len[3:0] = 4'b0;
    return SZ_W'(len - CW'(ilffa_pkg::BLK_BYTES));
  endfunction

  logic [ilffa_pkg::ADDR_W-1:0] base_q, rel_q, addr_q;
  logic [SZ_W-1:0]  end_off_q, off_q, prev_off_q, prev_sz_q, cur_sz_q, nsz_q;
  logic [SZ_W-1:0]  split_off_q, rest_q;
  logic [ilffa_pkg::REQ_W-1:0] req_q;
  logic             op_q, prev_free_q, right_q, fail_q, out_valid_q;
  ilffa_pkg::out_item_t out_q;

  logic [ENT_W-1:0] rdata, wdata;
  logic [IDX_W-1:0] raddr, waddr;
  logic             we;
  logic             rd_used;
  logic [SZ_W-1:0]  rd_sz, nxt_cur, rd_off, keep_off, total;
  logic [CW-1:0]    need_w, rest_w;
  logic [ilffa_pkg::ADDR_W-1:0] pa;
  logic             fit, split;

  assign rd_used = rdata[SZ_W];
  assign rd_sz   = rdata[SZ_W-1:0];
  assign nxt_cur = off_q + rd_sz;
  assign need_w  = (CW'(req_q) + CW'(ilffa_pkg::HDR_BYTES + ilffa_pkg::BLK_BYTES - 1))
                   & ~CW'(ilffa_pkg::BLK_BYTES - 1);
  assign rest_w  = CW'(rd_sz) - need_w;
  assign fit     = !rd_used && (CW'(rd_sz) >= CW'(req_q) + CW'(ilffa_pkg::HDR_BYTES));
  assign split   = rest_w >= CW'(ilffa_pkg::BLK_BYTES);
  assign pa      = base_q + ilffa_pkg::ADDR_W'(off_q) + ilffa_pkg::ADDR_W'(ilffa_pkg::HDR_BYTES);
  assign keep_off = prev_free_q ? prev_off_q : off_q;
  assign total   = cur_sz_q + (right_q ? nsz_q : '0) + (prev_free_q ? prev_sz_q : '0);
  assign rd_off  = cmd_i.rd_next ? (off_q + cur_sz_q) : off_q;
  assign raddr   = rd_off[IDX_W+3:4];

  assign sts_o.op_free  = (op_q == ilffa_pkg::OP_FREE);
  assign sts_o.at_end   = off_q >= end_off_q;
  assign sts_o.fit      = fit;
  assign sts_o.split    = split;
  assign sts_o.hit      = rd_used && (pa == rel_q);
  assign sts_o.next_in  = nxt_cur < end_off_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // Header store write port: one writer per command.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd_i.init_wr) begin
      we    = 1'b1;
      wdata = {1'b0, end_off_q};
    end else if (cmd_i.wr_alloc) begin
      we    = 1'b1;
      waddr = off_q[IDX_W+3:4];
      wdata = {1'b1, split ? SZ_W'(need_w) : rd_sz};
    end else if (cmd_i.wr_split) begin
      we    = 1'b1;
      waddr = split_off_q[IDX_W+3:4];
      wdata = {1'b0, rest_q};
    end else if (cmd_i.wr_merge) begin
      we    = 1'b1;
      waddr = keep_off[IDX_W+3:4];
      wdata = {1'b0, total};
    end
  end

  ilffa_ram #(
    .WIDTH(ENT_W),
    .DEPTH(DEPTH)
  ) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      end_off_q   <= end_of(ilffa_pkg::HEAP_BYTES_RST);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == ilffa_pkg::CFG_HEAP_BASE)) begin
        base_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == ilffa_pkg::CFG_HEAP_BYTES)) begin
        end_off_q <= end_of(cfg_wdata_i[ilffa_pkg::HB_W-1:0]);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q        <= in_data_i.opcode;
      req_q       <= in_data_i.request_bytes;
      rel_q       <= in_data_i.release_address;
      off_q       <= '0;
      prev_free_q <= 1'b0;
      fail_q      <= 1'b0;
      addr_q      <= '0;
    end
    if (cmd_i.step) begin
      off_q       <= nxt_cur;
      prev_off_q  <= off_q;
      prev_sz_q   <= rd_sz;
      prev_free_q <= !rd_used;
    end
    if (cmd_i.set_fail) begin
      fail_q <= 1'b1;
    end
    if (cmd_i.wr_alloc) begin
      addr_q      <= pa;
      split_off_q <= off_q + SZ_W'(need_w);
      rest_q      <= SZ_W'(rest_w);
    end
    if (cmd_i.hold_match) begin
      cur_sz_q <= rd_sz;
      right_q  <= 1'b0;
    end
    if (cmd_i.latch_next) begin
      nsz_q   <= rd_sz;
      right_q <= !rd_used;
    end
    if (cmd_i.out_load) begin
      out_q.failed          <= fail_q;
      out_q.payload_address <= addr_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/implicit_list_first_fit_allocator_unit.sv]
// Top level of the implicit-list first-fit heap allocator.
// Depends on ilffa_pkg, ilffa_ctrl, ilffa_dp (and through it ilffa_ram).

// The heap is kept as an implicit list of 16-byte aligned blocks; one header per 16-byte
// slot (size and allocated bit) lives in a single-port-write, registered-read RAM of
// HEAP_BYTES/16 entries. An allocate item walks the list from offset 0 and takes the first
// free block that fits, splitting off a free remainder of 16 bytes or more; a free item walks
// to the matching allocated block and merges it with free neighbors. Items are handled one
// at a time. Each visited block takes a header read, then a compare. An allocate item that fits
// ends with a split write when a free remainder is split off; a walk that runs off the end of
// the list ends in a failed result; a free item reads the right neighbor header when it lies
// inside the heap and then writes the merged header. A result held by a stalled receiver holds
// the walker in its last state. The result register lets a new item be accepted while the
// previous result waits. After reset, and after each heap_bytes write, the region is laid out
// again (one free block header at offset 0) before items are accepted; configuration is taken
// only when idle.
module implicit_list_first_fit_allocator_unit #(
  parameter int unsigned HEAP_BYTES = ilffa_pkg::HEAP_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ilffa_pkg::in_item_t          in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ilffa_pkg::out_item_t         out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_idx_i,
  input  logic [ilffa_pkg::ADDR_W-1:0] cfg_wdata_i
);

  ilffa_pkg::ctrl_cmd_t cmd;
  ilffa_pkg::ctrl_sts_t sts;
  logic                 cfg_we;

  // Register write happens on the valid/ready handshake.
  assign cfg_we = cfg_valid_i && cfg_ready_o;

  ilffa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .relayout_i (cfg_we && (cfg_idx_i == ilffa_pkg::CFG_HEAP_BYTES)),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ilffa_dp #(
    .HEAP_BYTES(HEAP_BYTES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

`ifndef NO_ASSERTIONS
  // An accepted item keeps the walker busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted back to back");

  // A fresh result is only loaded on the way back to idle.
  a_idle_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> cfg_ready_o)
    else $error("result loaded while walker busy");

  // A failed request never reports an address.
  a_fail_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.failed |-> out_data_o.payload_address == '0)
    else $error("failed result with nonzero address");
`endif

endmodule
